@@ rtl/core/tlc_pkg.sv @@
// Shared constants, types and the 6x8 font for the text line console.
package tlc_pkg;

  // Console geometry
  localparam int LINE_COUNT     = 4;
  localparam int CHARS_PER_LINE = 21;
  localparam int GLYPH_W        = 6;
  localparam int SLOT_W         = 2;
  localparam int POS_W          = 5;
  localparam int CODE_W         = 7;
  localparam int ADDR_W         = SLOT_W + POS_W;
  localparam int LINE_W         = 2;

  // Character codes
  localparam logic [CODE_W-1:0] CODE_QMARK = 7'd63;
  localparam logic [CODE_W-1:0] CODE_FIRST = 7'd32;

  // Request actions
  typedef enum logic [1:0] {
    ACT_APPEND   = 2'd0,
    ACT_END_LINE = 2'd1,
    ACT_READ     = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

  // Read request issued to the render stage
  typedef struct packed {
    logic       valid;
    logic       blank;
    logic [2:0] sub;
  } rd_issue_t;

  // Font: columns 0..5 from the most significant byte down, bit 0 top row
  localparam logic [47:0] GLYPHS [96] = '{
    48'h000000000000, 48'h00005F000000, 48'h000300030000, 48'h147F147F1400,
    48'h242A7F2A1200, 48'h231308646200, 48'h364955225000, 48'h000503000000,
    48'h001C22410000, 48'h0041221C0000, 48'h14083E081400, 48'h08083E080800,
    48'h005030000000, 48'h080808080800, 48'h006060000000, 48'h201008040200,
    48'h3E5149453E00, 48'h00427F400000, 48'h426151494600, 48'h2141454B3100,
    48'h1814127F1000, 48'h274545453900, 48'h3C4A49493000, 48'h017109050300,
    48'h364949493600, 48'h064949291E00, 48'h003636000000, 48'h005636000000,
    48'h081422410000, 48'h141414141400, 48'h004122140800, 48'h020151090600,
    48'h324979413E00, 48'h7E1111117E00, 48'h7F4949493600, 48'h3E4141412200,
    48'h7F4141221C00, 48'h7F4949494100, 48'h7F0909090100, 48'h3E4149497A00,
    48'h7F0808087F00, 48'h00417F410000, 48'h2040413F0100, 48'h7F0814224100,
    48'h7F4040404000, 48'h7F020C027F00, 48'h7F0408107F00, 48'h3E4141413E00,
    48'h7F0909090600, 48'h3E4151215E00, 48'h7F0919294600, 48'h464949493100,
    48'h01017F010100, 48'h3F4040403F00, 48'h1F2040201F00, 48'h3F4038403F00,
    48'h631408146300, 48'h070870080700, 48'h615149454300, 48'h007F41410000,
    48'h020408102000, 48'h0041417F0000, 48'h040201020400, 48'h404040404000,
    48'h000102000000, 48'h205454547800, 48'h7F4844443800, 48'h384444442000,
    48'h384444487F00, 48'h385454541800, 48'h087E09010200, 48'h0C5252523E00,
    48'h7F0804047800, 48'h00447D400000, 48'h2040443D0000, 48'h7F1028440000,
    48'h00417F400000, 48'h7C0418047800, 48'h7C0804047800, 48'h384444443800,
    48'h7C1414140800, 48'h081414187C00, 48'h7C0804040800, 48'h485454542400,
    48'h043F44402000, 48'h3C4040207C00, 48'h1C2040201C00, 48'h3C4030403C00,
    48'h442810284400, 48'h0C5050503C00, 48'h4464544C4400, 48'h083641000000,
    48'h00007F000000, 48'h004136080000, 48'h100810080000, 48'h000000000000
  };

  // One vertical byte of a glyph; codes below the printable range draw as '?'
  function automatic logic [7:0] glyph_column(logic [CODE_W-1:0] code, logic [2:0] sub);
    logic [CODE_W-1:0] c;
    logic [CODE_W-1:0] idx;
    logic [47:0]       row;
    logic [2:0]        sh;
    c   = (code < CODE_FIRST) ? CODE_QMARK : code;
    idx = c - CODE_FIRST;
    row = GLYPHS[idx];
    sh  = 3'd5 - sub;
    return 8'(row >> {sh, 3'b000});
  endfunction

endpackage

@@ rtl/core/tlc_if.sv @@
// Request and response channel interfaces of the text line console.
interface tlc_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] char_code;
  logic [2:0] page;
  logic [6:0] column;

  modport source (output valid, action, char_code, page, column, input ready);
  modport sink (input valid, action, char_code, page, column, output ready);
endinterface

interface tlc_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;

  modport source (output valid, pixel_byte, input ready);
  modport sink (input valid, pixel_byte, output ready);
endinterface

@@ rtl/core/text_line_console_renderer.sv @@
// Top level of the four-line scrolling text console with 6x8 font rendering.
// Requests append a character, end the current line, or read one vertical
// pixel byte of the 128x64 picture at a page and column. One request is
// accepted per clock unless the render stage stalls; a read passes through
// the registered character RAM read and then the font lookup into the
// response register. While a response waits to be taken, the RAM read
// stage still takes one more request before requests stall. Line
// lengths, ring head and write position reset to zero; the character RAM is
// not cleared, since only written entries are ever shown.
module text_line_console_renderer (
  input  logic       clk,
  input  logic       rst,
  tlc_req_if.sink    cmd,
  tlc_rsp_if.source  rsp
);

  tlc_pkg::rd_issue_t         issue;
  logic                       issue_ready;
  logic                       ram_we;
  logic [tlc_pkg::ADDR_W-1:0] ram_waddr;
  logic [tlc_pkg::CODE_W-1:0] ram_wdata;
  logic                       ram_re;
  logic [tlc_pkg::ADDR_W-1:0] ram_raddr;
  logic [tlc_pkg::CODE_W-1:0] ram_rdata;

  tlc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .issue_ready (issue_ready),
    .issue       (issue),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr)
  );

  tlc_char_ram #(
    .ADDR_W (tlc_pkg::ADDR_W),
    .DATA_W (tlc_pkg::CODE_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tlc_render u_render (
    .clk         (clk),
    .rst         (rst),
    .issue       (issue),
    .ram_rdata   (ram_rdata),
    .issue_ready (issue_ready),
    .rsp         (rsp)
  );

endmodule

@@ rtl/core/tlc_char_ram.sv @@
// Simple dual-port character RAM with registered read.
module tlc_char_ram #(
  parameter int ADDR_W = 7,
  parameter int DATA_W = 7
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/tlc_ctrl.sv @@
// Line ring control: appends, line ends and read address generation.
module tlc_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  tlc_req_if.sink                         cmd,
  input  logic                            issue_ready,
  output tlc_pkg::rd_issue_t              issue,
  output logic                            ram_we,
  output logic [tlc_pkg::ADDR_W-1:0]      ram_waddr,
  output logic [tlc_pkg::CODE_W-1:0]      ram_wdata,
  output logic                            ram_re,
  output logic [tlc_pkg::ADDR_W-1:0]      ram_raddr
);

  logic [tlc_pkg::SLOT_W-1:0] head;
  logic [tlc_pkg::POS_W-1:0]  wpos;
  logic [tlc_pkg::POS_W-1:0]  len [tlc_pkg::LINE_COUNT];

  logic                        accept;
  logic                        do_append;
  logic                        do_end;
  logic                        do_read;
  logic                        room;
  logic [tlc_pkg::SLOT_W-1:0]  head_inc;
  logic [tlc_pkg::CODE_W-1:0]  code;
  logic [tlc_pkg::LINE_W-1:0]  line;
  logic [tlc_pkg::SLOT_W:0]    slot_sum;
  logic [tlc_pkg::SLOT_W-1:0]  rd_slot;
  logic [12:0]                 prod;
  logic [tlc_pkg::POS_W-1:0]   k;
  logic [6:0]                  k_x6;
  logic                        blank;

  assign cmd.ready = issue_ready;
  assign accept    = cmd.valid && issue_ready;
  assign do_append = accept && (cmd.action == tlc_pkg::ACT_APPEND);
  assign do_end    = accept && (cmd.action == tlc_pkg::ACT_END_LINE);
  assign do_read   = accept && (cmd.action == tlc_pkg::ACT_READ);
  assign room      = wpos < tlc_pkg::POS_W'(tlc_pkg::CHARS_PER_LINE);
  assign head_inc  = (head == tlc_pkg::SLOT_W'(tlc_pkg::LINE_COUNT - 1)) ?
                     '0 : head + 1'b1;

  // Character mapping: codes outside 32..127 stored as '?'
  assign code = (cmd.char_code < 8'd32 || cmd.char_code > 8'd127) ?
                tlc_pkg::CODE_QMARK : cmd.char_code[6:0];

  // Append write
  assign ram_we    = do_append && room;
  assign ram_waddr = {head, wpos};
  assign ram_wdata = code;

  // Display line to ring slot
  assign line     = cmd.page[2:1];
  assign slot_sum = {1'b0, head} + (tlc_pkg::SLOT_W + 1)'(line);
  assign rd_slot  = (slot_sum >= (tlc_pkg::SLOT_W + 1)'(tlc_pkg::LINE_COUNT)) ?
                    tlc_pkg::SLOT_W'(slot_sum - (tlc_pkg::SLOT_W + 1)'(tlc_pkg::LINE_COUNT)) :
                    slot_sum[tlc_pkg::SLOT_W-1:0];

  // Character index: column / 6 by reciprocal (exact below 128), remainder by subtract
  assign prod = 13'(cmd.column) * 13'd43;
  assign k    = prod[12:8];
  assign k_x6 = 7'({k, 2'b00}) + 7'({k, 1'b0});

  assign blank = cmd.page[0]
              || ({1'b0, line} >= (tlc_pkg::LINE_W + 1)'(tlc_pkg::LINE_COUNT))
              || (k >= tlc_pkg::POS_W'(tlc_pkg::CHARS_PER_LINE))
              || (k >= len[rd_slot]);

  assign ram_re    = do_read;
  assign ram_raddr = {rd_slot, k};

  always_comb begin
    issue.valid = do_read;
    issue.blank = blank;
    issue.sub   = 3'(cmd.column - k_x6);
  end

  // Ring state
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      wpos <= '0;
      for (int i = 0; i < tlc_pkg::LINE_COUNT; i++) begin
        len[i] <= '0;
      end
    end else if (do_append) begin
      if (room) begin
        wpos      <= wpos + 1'b1;
        len[head] <= wpos + 1'b1;
      end
    end else if (do_end) begin
      if (wpos == '0) begin
        len[head] <= '0;
      end
      head <= head_inc;
      wpos <= '0;
    end
  end

endmodule

@@ rtl/core/tlc_render.sv @@
// Render stage: glyph lookup on RAM data and the response register.
module tlc_render (
  input  logic                       clk,
  input  logic                       rst,
  input  tlc_pkg::rd_issue_t         issue,
  input  logic [tlc_pkg::CODE_W-1:0] ram_rdata,
  output logic                       issue_ready,
  tlc_rsp_if.source                  rsp
);

  logic       s1_valid;
  logic       s1_blank;
  logic [2:0] s1_sub;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       move;

  assign move        = s1_valid && (!out_valid || rsp.ready);
  assign issue_ready = !s1_valid || move;

  // RAM read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (issue.valid) begin
      s1_valid <= 1'b1;
    end else if (move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue.valid) begin
      s1_blank <= issue.blank;
      s1_sub   <= issue.sub;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_byte <= s1_blank ? 8'h00 : tlc_pkg::glyph_column(ram_rdata, s1_sub);
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.pixel_byte = out_byte;

endmodule

@@ rtl/core/tlc_checker.sv @@
// Port-level checks of the text line console, bound to the top level.
module tlc_checker (
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_ready,
  input logic [1:0] cmd_action,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [7:0] rsp_pixel_byte
);

  // No response straight out of reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // Stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_byte))
    else $error("stalled response changed");

  // A read taken behind a stalled response fills the read stage
  a_read_backpressure: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready && cmd_valid && cmd_ready && cmd_action == tlc_pkg::ACT_READ
    |=> rsp_ready || !cmd_ready)
    else $error("request taken with response and read stage both full");

endmodule

bind text_line_console_renderer tlc_checker u_tlc_checker (
  .clk            (clk),
  .rst            (rst),
  .cmd_valid      (cmd.valid),
  .cmd_ready      (cmd.ready),
  .cmd_action     (cmd.action),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_pixel_byte (rsp.pixel_byte)
);
